/* rtl/core/pdd_pkg.sv */
//------------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants for the pair duplicate detector.
//------------------------------------------------------------------------------
`default_nettype none
package pdd_pkg;
    localparam int MaxEntries = 256;
    localparam logic [63:0] AbsMask = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] InfBits = 64'h7FF0_0000_0000_0000;

    typedef struct packed {
        logic [63:0] x_value;
        logic [63:0] y_value;
        logic        last_item;
    } t_in_beat;

    typedef struct packed {
        logic is_duplicate;
        logic store_full;
    } t_out_beat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_DONE
    } t_state;

    function automatic logic fp_equal(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        ma = a & AbsMask;
        mb = b & AbsMask;
        if (ma > InfBits || mb > InfBits) begin
            return 1'b0;
        end
        if (ma == 64'd0 && mb == 64'd0) begin
            return 1'b1;
        end
        return a == b;
    endfunction
endpackage
`default_nettype wire

/* rtl/core/pair_duplicate_detector.sv */
//------------------------------------------------------------------------------
// pair_duplicate_detector
// Flags (x,y) double pairs already seen in the current vector.
//------------------------------------------------------------------------------
// From start the beat is scanned against the n pairs stored, then ST_WAIT and ST_DONE, where it strobes.
// One beat at a time: the memory read port scans one entry per cycle.
// start is taken only in idle; busy stays high until the result has been strobed.
// Reset clears the fill count and control; the memories are not cleared.
// The receiver cannot stall; each result shows for one cycle.
`default_nettype none
module pair_duplicate_detector #(
    parameter int MAX_ENTRIES = pdd_pkg::MaxEntries
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    output logic              busy,
    input  pdd_pkg::t_in_beat i_data,
    output logic              o_strobe,
    output pdd_pkg::t_out_beat o_data
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam logic [CW-1:0] Full = CW'(MAX_ENTRIES);

    logic [127:0] mem [MAX_ENTRIES];
    logic [127:0] r_rd;

    pdd_pkg::t_state r_state, n_state;
    pdd_pkg::t_in_beat r_in;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic r_dup, n_dup;
    logic r_vld, n_vld;
    logic wr_en;
    logic rd_en;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            pdd_pkg::ST_IDLE: if (start) begin
                n_state = pdd_pkg::ST_SCAN;
            end
            pdd_pkg::ST_SCAN: if (r_idx == r_count) begin
                n_state = pdd_pkg::ST_WAIT;
            end
            pdd_pkg::ST_WAIT: n_state = pdd_pkg::ST_DONE;
            pdd_pkg::ST_DONE: n_state = pdd_pkg::ST_IDLE;
            default: n_state = pdd_pkg::ST_IDLE;
        endcase
    end

    // Outputs and datapath control.
    always_comb begin
        busy    = (r_state != pdd_pkg::ST_IDLE);
        rd_en   = (r_state == pdd_pkg::ST_SCAN) && (r_idx != r_count);
        n_idx   = r_idx;
        n_vld   = rd_en;
        n_dup   = r_dup;
        n_count = r_count;
        wr_en   = 1'b0;
        case (r_state)
            pdd_pkg::ST_IDLE: begin
                n_idx = '0;
                n_dup = 1'b0;
            end
            pdd_pkg::ST_SCAN: if (rd_en) begin
                n_idx = r_idx + 1'b1;
            end
            pdd_pkg::ST_WAIT: begin
            end
            pdd_pkg::ST_DONE: begin
                n_idx = '0;
                wr_en = (r_count != Full);
                if (r_in.last_item) begin
                    n_count = '0;
                end else if (wr_en) begin
                    n_count = r_count + 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (r_vld && pdd_pkg::fp_equal(r_rd[127:64], r_in.x_value)
                && pdd_pkg::fp_equal(r_rd[63:0], r_in.y_value)) begin
            n_dup = 1'b1;
        end
        o_strobe            = (r_state == pdd_pkg::ST_DONE);
        o_data.is_duplicate = r_dup;
        o_data.store_full   = (r_count == Full);
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd <= mem[r_idx[AW-1:0]];
        end
        if (wr_en) begin
            mem[r_count[AW-1:0]] <= {r_in.x_value, r_in.y_value};
        end
        if (r_state == pdd_pkg::ST_IDLE && start) begin
            r_in <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdd_pkg::ST_IDLE;
            r_count <= '0;
            r_idx   <= '0;
            r_dup   <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_dup   <= n_dup;
            r_vld   <= n_vld;
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Full) else $error("fill count beyond depth");
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count) else $error("scan index beyond fill count");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && r_in.last_item |=> r_count == '0)
        else $error("last beat did not clear store");
    a_strobe_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe) else $error("double strobe");
endmodule
`default_nettype wire

/* tb/testbench.sv */
//------------------------------------------------------------------------------
// testbench
// Drives (x,y) double pairs into the pair duplicate detector in vectors of
// varied length, predicts the duplicate and full flags of every beat, and
// compares each strobed result with the oldest prediction.
//------------------------------------------------------------------------------
class pair_flag_board;
    localparam int Depth = pdd_pkg::MaxEntries;
    logic [63:0] kept_x[Depth];
    logic [63:0] kept_y[Depth];
    int kept_count;
    pdd_pkg::t_out_beat flags_due[$];
    int mismatches;

    function new();
        kept_count = 0;
        mismatches = 0;
    endfunction

    function bit coord_equal(logic [63:0] a, logic [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        ma = a & 64'h7FFF_FFFF_FFFF_FFFF;
        mb = b & 64'h7FFF_FFFF_FFFF_FFFF;
        if (ma > 64'h7FF0_0000_0000_0000 || mb > 64'h7FF0_0000_0000_0000) return 1'b0;
        if (ma == '0 && mb == '0) return 1'b1;
        return a == b;
    endfunction

    function void note_pair(pdd_pkg::t_in_beat beat);
        pdd_pkg::t_out_beat flags;
        flags = '0;
        for (int i = 0; i < kept_count; i++) begin
            if (coord_equal(kept_x[i], beat.x_value)
                    && coord_equal(kept_y[i], beat.y_value)) begin
                flags.is_duplicate = 1'b1;
                break;
            end
        end
        if (kept_count < Depth) begin
            kept_x[kept_count] = beat.x_value;
            kept_y[kept_count] = beat.y_value;
            kept_count++;
        end else begin
            flags.store_full = 1'b1;
        end
        if (beat.last_item) kept_count = 0;
        flags_due.push_back(flags);
    endfunction

    function void check_flags(pdd_pkg::t_out_beat got);
        pdd_pkg::t_out_beat want;
        if (flags_due.size() == 0) begin
            $error("result strobe with no beat outstanding");
            mismatches++;
            return;
        end
        want = flags_due.pop_front();
        if (got.is_duplicate !== want.is_duplicate) begin
            $error("is_duplicate expected %0b actual %0b", want.is_duplicate, got.is_duplicate);
            mismatches++;
        end
        if (got.store_full !== want.store_full) begin
            $error("store_full expected %0b actual %0b", want.store_full, got.store_full);
            mismatches++;
        end
    endfunction
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    pdd_pkg::t_in_beat i_data = '0;
    logic o_strobe;
    pdd_pkg::t_out_beat o_data;

    pair_flag_board board = new();
    logic [63:0] pool[$];
    bit quiet_stretch;

    pair_duplicate_detector u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_strobe(o_strobe),
        .o_data  (o_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) board.check_flags(o_data);
    end

    task automatic send_pair(logic [63:0] x, logic [63:0] y, logic last);
        while (!quiet_stretch && $urandom_range(99) < 36) @(negedge i_clk);
        while (busy) @(negedge i_clk);
        start <= 1'b1;
        i_data <= '{x_value: x, y_value: y, last_item: last};
        @(posedge i_clk);
        board.note_pair('{x_value: x, y_value: y, last_item: last});
        @(negedge i_clk);
        start <= 1'b0;
    endtask

    function automatic logic [63:0] pick_value();
        logic [63:0] v;
        case ($urandom_range(9))
            0: v = 64'h0000_0000_0000_0000;
            1: v = 64'h8000_0000_0000_0000;
            2: v = 64'h7FF8_0000_0000_0000;
            3: v = {1'($urandom_range(1)), 11'h7FF, 20'h0, 32'h0};
            4: v = {1'($urandom_range(1)), 11'h7FF, 20'($urandom_range(1)), 31'h0,
                    1'($urandom_range(1, 1))};
            5, 6, 7: v = pool[$urandom_range(pool.size() - 1)];
            default: v = {$urandom, $urandom};
        endcase
        return v;
    endfunction

    task automatic send_vector(int len);
        logic [63:0] x;
        logic [63:0] y;
        for (int i = 0; i < len; i++) begin
            x = pick_value();
            y = pick_value();
            if ($urandom_range(3) == 0 && pool.size() > 1) begin
                x = pool[$urandom_range(pool.size() - 1)];
                y = pool[$urandom_range(pool.size() - 1)];
            end
            send_pair(x, y, i == len - 1);
        end
    endtask

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int sent;
        int len;
        quiet_stretch = 1'b0;
        for (int i = 0; i < 12; i++) pool.push_back({$urandom, $urandom});
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_pair(64'h0, 64'h0, 1'b0);
        send_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0);
        send_pair(64'h7FF8_0000_0000_0000, 64'h1, 1'b0);
        send_pair(64'h7FF8_0000_0000_0000, 64'h1, 1'b0);
        send_pair(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_pair(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1'b0);
        send_pair(64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 1'b0);
        send_pair(64'h7FF0_0000_0000_0001, 64'h0, 1'b1);
        send_pair(64'h0, 64'h0, 1'b1);
        send_pair(64'h0, 64'h0, 1'b1);

        // Overfill one vector so that later pairs are checked but not kept.
        for (int i = 0; i < pdd_pkg::MaxEntries; i++) send_pair(64'(i), 64'h5, 1'b0);
        send_pair(64'h3, 64'h5, 1'b0);
        send_pair(64'h1234, 64'h5, 1'b0);
        send_pair(64'h1234, 64'h5, 1'b1);

        sent = 0;
        while (sent < 730) begin
            quiet_stretch = (sent >= 400 && sent < 550);
            len = ($urandom_range(19) == 0) ? $urandom_range(200, 260) : $urandom_range(1, 12);
            send_vector(len);
            sent += len;
        end

        while (board.flags_due.size() != 0) @(posedge i_clk);
        repeat (pdd_pkg::MaxEntries + 10) @(posedge i_clk);
        if (board.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
